// ===== rtl/cxk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxk_pkg
// Shared types, constants and round functions for the ChaCha20 XOR core.
// ----------------------------------------------------------------------------
package cxk_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
  localparam int ROUND_CNT_W   = $clog2(ROUNDS);
  localparam int DATA_W        = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int POS_W         = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_01      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_CTR   = 3'd6;

  localparam logic [POS_W-1:0] LAST_POS = 3'd7;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;
  typedef word_t [3:0]  quad_t;

  typedef struct packed {
    word_t [7:0] key;
    word_t [2:0] nonce;
  } cipher_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    word_t             ctr;
    logic              need_block;
  } q_entry_t;

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic quad_t quarter(input word_t a, input word_t b,
                                    input word_t c, input word_t d);
    word_t ta, tb, tc, td;
    ta = a + b; td = rotl(d ^ ta, 16);
    tc = c + td; tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    quarter = {td, tc, tb, ta};
  endfunction

  // one column round or one diagonal round
  function automatic state_t half_round(input state_t s, input logic diag);
    state_t r;
    quad_t q0, q1, q2, q3;
    r = s;
    if (!diag) begin
      q0 = quarter(s[0], s[4], s[8],  s[12]);
      q1 = quarter(s[1], s[5], s[9],  s[13]);
      q2 = quarter(s[2], s[6], s[10], s[14]);
      q3 = quarter(s[3], s[7], s[11], s[15]);
      r[0] = q0[0]; r[4] = q0[1]; r[8]  = q0[2]; r[12] = q0[3];
      r[1] = q1[0]; r[5] = q1[1]; r[9]  = q1[2]; r[13] = q1[3];
      r[2] = q2[0]; r[6] = q2[1]; r[10] = q2[2]; r[14] = q2[3];
      r[3] = q3[0]; r[7] = q3[1]; r[11] = q3[2]; r[15] = q3[3];
    end else begin
      q0 = quarter(s[0], s[5], s[10], s[15]);
      q1 = quarter(s[1], s[6], s[11], s[12]);
      q2 = quarter(s[2], s[7], s[8],  s[13]);
      q3 = quarter(s[3], s[4], s[9],  s[14]);
      r[0] = q0[0]; r[5] = q0[1]; r[10] = q0[2]; r[15] = q0[3];
      r[1] = q1[0]; r[6] = q1[1]; r[11] = q1[2]; r[12] = q1[3];
      r[2] = q2[0]; r[7] = q2[1]; r[8]  = q2[2]; r[13] = q2[3];
      r[3] = q3[0]; r[4] = q3[1]; r[9]  = q3[2]; r[14] = q3[3];
    end
    half_round = r;
  endfunction

endpackage

// ===== rtl/cxk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxk_in_if / cxk_out_if
// Valid/ready channels for data words in and cipher words out.
// ----------------------------------------------------------------------------
interface cxk_in_if;
  import cxk_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  logic              restart;
  modport source(output valid, data_word, restart, input ready);
  modport sink(input valid, data_word, restart, output ready);
endinterface

interface cxk_out_if;
  import cxk_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] cipher_word;
  logic              end_of_block;
  modport source(output valid, cipher_word, end_of_block, input ready);
  modport sink(input valid, cipher_word, end_of_block, output ready);
endinterface

// ===== rtl/cxk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxk_front
// Tracks word position and block counter, tags each word for the back end.
// ----------------------------------------------------------------------------
module cxk_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [cxk_pkg::DATA_W-1:0]    in_data_word,
  input  logic                          in_restart,
  output logic                          in_ready,
  input  cxk_pkg::word_t                start_counter,
  input  logic                          q_full,
  output logic                          q_push,
  output cxk_pkg::q_entry_t             q_entry
);
  import cxk_pkg::*;

  word_t            block_counter_r, block_counter_nxt;
  logic [POS_W-1:0] word_pos_r, word_pos_nxt;
  logic             ks_ready_r, ks_ready_nxt;
  word_t            cur_ctr;
  logic [POS_W-1:0] cur_pos;
  logic             cur_need;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    cur_ctr  = in_restart ? start_counter : block_counter_r;
    cur_pos  = in_restart ? '0 : word_pos_r;
    cur_need = in_restart ? 1'b1 : !ks_ready_r;
    q_entry  = '{data: in_data_word, pos: cur_pos, ctr: cur_ctr, need_block: cur_need};
    block_counter_nxt = block_counter_r;
    word_pos_nxt      = word_pos_r;
    ks_ready_nxt      = ks_ready_r;
    if (q_push) begin
      word_pos_nxt = cur_pos + POS_W'(1);
      if (cur_pos == LAST_POS) begin
        block_counter_nxt = cur_ctr + 32'd1;
        ks_ready_nxt      = 1'b0;
      end else begin
        block_counter_nxt = cur_ctr;
        ks_ready_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_counter_r <= '0;
      word_pos_r      <= '0;
      ks_ready_r      <= 1'b0;
    end else begin
      block_counter_r <= block_counter_nxt;
      word_pos_r      <= word_pos_nxt;
      ks_ready_r      <= ks_ready_nxt;
    end
  end

endmodule

// ===== rtl/cxk_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxk_queue
// Small FIFO of tagged words between the front and back ends.
// ----------------------------------------------------------------------------
module cxk_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cxk_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output cxk_pkg::q_entry_t head
);
  import cxk_pkg::*;

  q_entry_t                slots_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]  count_r;

  assign full       = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      count_r <= count_r + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/cxk_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxk_back
// Runs the ChaCha20 rounds, keeps the keystream block and XORs each word.
// ----------------------------------------------------------------------------
module cxk_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cxk_pkg::cipher_cfg_t          cfg,
  input  logic                          head_valid,
  input  cxk_pkg::q_entry_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cxk_pkg::DATA_W-1:0]    out_cipher_word,
  output logic                          out_end_of_block
);
  import cxk_pkg::*;

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_ROUND = 3'b010,
    S_FINAL = 3'b100
  } back_state_t;

  back_state_t             state_r, state_nxt;
  logic [ROUND_CNT_W-1:0]  round_cnt_r;
  state_t                  work_r, init_r, init_st;
  logic [DATA_W-1:0]       ks_store_r [8];
  logic                    fresh_r;
  logic                    out_valid_r;
  logic [DATA_W-1:0]       out_word_r;
  logic                    out_eob_r;
  logic                    start_blk;

  assign out_valid        = out_valid_r;
  assign out_cipher_word  = out_word_r;
  assign out_end_of_block = out_eob_r;

  always_comb begin
    init_st = {cfg.nonce[2], cfg.nonce[1], cfg.nonce[0], head.ctr,
               cfg.key[7], cfg.key[6], cfg.key[5], cfg.key[4],
               cfg.key[3], cfg.key[2], cfg.key[1], cfg.key[0],
               SIGMA3, SIGMA2, SIGMA1, SIGMA0};
  end

  always_comb begin
    start_blk = (state_r == S_RUN) && head_valid && head.need_block && !fresh_r;
    pop = (state_r == S_RUN) && head_valid && !(head.need_block && !fresh_r)
          && (!out_valid_r || out_ready);
    state_nxt = state_r;
    case (state_r)
      S_RUN:   if (start_blk) state_nxt = S_ROUND;
      S_ROUND: if (round_cnt_r == ROUND_CNT_W'(ROUNDS - 1)) state_nxt = S_FINAL;
      S_FINAL: state_nxt = S_RUN;
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_blk) begin
      init_r <= init_st;
      work_r <= init_st;
    end else if (state_r == S_ROUND) begin
      work_r <= half_round(work_r, round_cnt_r[0]);
    end
    if (state_r == S_FINAL) begin
      for (int i = 0; i < 8; i++) begin
        ks_store_r[i] <= {work_r[2*i+1] + init_r[2*i+1], work_r[2*i] + init_r[2*i]};
      end
    end
    if (pop) begin
      out_word_r <= head.data ^ ks_store_r[head.pos];
      out_eob_r  <= (head.pos == LAST_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      round_cnt_r <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start_blk) begin
        round_cnt_r <= '0;
      end else if (state_r == S_ROUND) begin
        round_cnt_r <= round_cnt_r + ROUND_CNT_W'(1);
      end
      if (state_r == S_FINAL) begin
        fresh_r <= 1'b1;
      end else if (pop) begin
        fresh_r <= 1'b0;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/chacha20_keystream_xor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_core
// ChaCha20 (96-bit nonce) keystream XOR over 64-bit little-endian words.
// A word taken in is queued, then XORed into a registered result once its block
// exists; the first word of a block waits for the block (load, 20 single rounds,
// final add). Throughput: 1 word per cycle within a block unless the output stalls;
// blocks use the single shared round unit. Synchronous active-low reset clears
// counters, queue and handshake state; config registers reset to zero.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_core (
  input  logic                              clk,
  input  logic                              rst_n,
  cxk_in_if.sink                            in_ch,
  cxk_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cxk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cxk_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cxk_pkg::*;

  cipher_cfg_t cfg_r;
  word_t       start_ctr_r;
  logic        q_full, q_push, q_pop, q_head_valid;
  q_entry_t    q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      start_ctr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_01:     cfg_r.key[1:0] <= cfg_data;
        REG_KEY_23:     cfg_r.key[3:2] <= cfg_data;
        REG_KEY_45:     cfg_r.key[5:4] <= cfg_data;
        REG_KEY_67:     cfg_r.key[7:6] <= cfg_data;
        REG_NONCE_LOW:  cfg_r.nonce[1:0] <= cfg_data;
        REG_NONCE_HIGH: cfg_r.nonce[2] <= cfg_data[31:0];
        REG_START_CTR:  start_ctr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cxk_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_data_word(in_ch.data_word),
    .in_restart(in_ch.restart), .in_ready(in_ch.ready),
    .start_counter(start_ctr_r),
    .q_full, .q_push, .q_entry(q_in)
  );

  cxk_queue u_queue (
    .clk, .rst_n,
    .push(q_push), .push_entry(q_in), .full(q_full),
    .pop(q_pop), .head_valid(q_head_valid), .head(q_head)
  );

  cxk_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .head_valid(q_head_valid), .head(q_head), .pop(q_pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_cipher_word(out_ch.cipher_word), .out_end_of_block(out_ch.end_of_block)
  );

endmodule

// ===== rtl/cxk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxk_checker
// Port-level checks on the ChaCha20 XOR core, bound to the top level.
// ----------------------------------------------------------------------------
module cxk_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cxk_pkg::DATA_W-1:0]    out_cipher_word,
  input logic                          out_end_of_block
);
  import cxk_pkg::*;

  logic [3:0] pending_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_word)
    && $stable(out_end_of_block)) else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0) else $error("result without transfer in");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'(QUEUE_DEPTH + 1)) else $error("too many words in flight");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

endmodule

bind chacha20_keystream_xor_core cxk_checker u_cxk_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_cipher_word(out_ch.cipher_word), .out_end_of_block(out_ch.end_of_block)
);
